// ===== design/rst_pkg.sv =====
// Package with shared constants and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package rst_pkg;
    localparam int CAPACITY = 64;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int LEN_W = IDX_W + 1;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_RANDOM = 2'd2;

    localparam logic [2:0] ST_DONE   = 3'd0;
    localparam logic [2:0] ST_REJECT = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_RETRY  = 3'd4;

    typedef struct packed {
        logic load;        // capture the input item
        logic scan_start;  // reset scan index to zero
        logic scan_step;   // advance scan index
        logic rnd_start;   // start modulo reduction
        logic rnd_step;    // one restoring division step
        logic rd_slot;     // read slot at random position
        logic do_insert;   // write value into target slot
        logic do_remove;   // free the found slot
        logic pack_step;   // move one slot during compaction
        logic pack_end;    // finish compaction
        logic fifo_rd;     // read FIFO head
    } rst_cmd_t;

    typedef struct packed {
        logic scan_done;   // scan index reached used length
        logic hit;         // live slot at scan index matches value
        logic rnd_done;    // modulo finished
        logic slot_live;   // live bit at random position
        logic empty;       // used length is zero
        logic have_free;   // free count nonzero
        logic full;        // used length equals capacity
        logic need_pack;   // compaction threshold exceeded after remove
        logic pack_done;   // compaction swept all used slots
    } rst_sts_t;
endpackage
`default_nettype wire

// ===== design/randomized_set_table_unit.sv =====
// Top level of the randomized set table: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// The unit keeps a set of up to 64 signed 32-bit values and handles one
// request at a time. Insert and remove first scan the used slots for the
// value, reading and then testing each slot in turn; a remove that triggers
// compaction adds a packing sweep through the slot memory. Get random runs
// a 32-step restoring division to form random_word modulo used_length.
// One result transfer follows each input transfer, and the input is not
// ready again until that result has been taken. Retry status means the
// chosen slot was free; the caller should send a new random word.
module randomized_set_table_unit import rst_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic  [1:0] action,
    input  wire logic signed [31:0] item_value,
    input  wire logic [31:0] random_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic       [2:0] status,
    output logic signed [31:0] picked_value
);
    rst_cmd_t cmd;
    rst_sts_t sts;
    logic [31:0] slot_rdata;
    logic [31:0] pick;

    rst_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_action    (action),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .picked_value (pick),
        .slot_rdata   (slot_rdata),
        .sts          (sts),
        .cmd          (cmd)
    );

    rst_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_value   (item_value),
        .in_random  (random_word),
        .sts        (sts),
        .slot_rdata (slot_rdata)
    );

    assign picked_value = pick;
endmodule
`default_nettype wire

// ===== design/rst_datapath.sv =====
// Datapath: slot memory, live bits, free FIFO, counters, scan and modulo units.
`timescale 1ns / 1ps
`default_nettype none
module rst_datapath import rst_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rst_cmd_t           cmd,
    input  wire logic        [31:0] in_value,
    input  wire logic        [31:0] in_random,
    output rst_sts_t                sts,
    output logic             [31:0] slot_rdata
);
    logic [31:0] slot_mem [CAPACITY];
    logic [IDX_W-1:0] fifo_mem [CAPACITY];

    logic [CAPACITY-1:0] live_reg;
    logic [LEN_W-1:0] used_reg, free_cnt_reg;
    logic [IDX_W-1:0] head_reg, tail_reg;
    logic [31:0] value_reg;
    logic [LEN_W-1:0] scan_reg;   // scan read pointer
    logic [LEN_W-1:0] wr_reg;     // compaction write pointer
    logic [31:0] rem_reg, quo_reg;
    logic [5:0] bit_reg;
    logic rnd_busy_reg;
    logic [IDX_W-1:0] fifo_q_reg;
    logic [31:0] slot_q_reg;
    logic [IDX_W-1:0] scan_idx;
    logic [32:0] trial;
    logic [IDX_W-1:0] pos;

    assign scan_idx = scan_reg[IDX_W-1:0];
    assign trial = {rem_reg, quo_reg[31]} - {{(33-LEN_W){1'b0}}, used_reg};
    assign pos = rem_reg[IDX_W-1:0];

    // Slot memory: one synchronous read at the scan pointer or the random position, one write.
    always_ff @(posedge clk)
    begin
        slot_q_reg <= slot_mem[cmd.rd_slot ? pos : scan_idx];
        if (cmd.do_insert)
        begin
            slot_mem[cmd.fifo_rd ? fifo_q_reg : used_reg[IDX_W-1:0]] <= value_reg;
        end
        else if (cmd.pack_step && live_reg[scan_idx])
        begin
            slot_mem[wr_reg[IDX_W-1:0]] <= slot_q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fifo_q_reg <= fifo_mem[head_reg];
        if (cmd.do_remove)
        begin
            fifo_mem[tail_reg] <= scan_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= in_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg     <= '0;
            used_reg     <= '0;
            free_cnt_reg <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            scan_reg     <= '0;
            wr_reg       <= '0;
            rem_reg      <= '0;
            quo_reg      <= '0;
            bit_reg      <= '0;
            rnd_busy_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                scan_reg <= '0;
                wr_reg   <= '0;
            end
            else if (cmd.scan_step)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.rnd_start)
            begin
                rem_reg      <= '0;
                quo_reg      <= in_random;
                bit_reg      <= 6'd32;
                rnd_busy_reg <= 1'b1;
            end
            else if (cmd.rnd_step && bit_reg != 6'd0)
            begin
                rem_reg <= trial[32] ? {rem_reg[30:0], quo_reg[31]} : trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
                bit_reg <= bit_reg - 1'b1;
            end
            if (cmd.do_insert)
            begin
                if (cmd.fifo_rd)
                begin
                    live_reg[fifo_q_reg] <= 1'b1;
                    head_reg <= head_reg + 1'b1;
                    free_cnt_reg <= free_cnt_reg - 1'b1;
                end
                else
                begin
                    live_reg[used_reg[IDX_W-1:0]] <= 1'b1;
                    used_reg <= used_reg + 1'b1;
                end
            end
            if (cmd.do_remove)
            begin
                live_reg[scan_idx] <= 1'b0;
                tail_reg <= tail_reg + 1'b1;
                free_cnt_reg <= free_cnt_reg + 1'b1;
            end
            if (cmd.pack_step)
            begin
                // Moves are safe in place since wr never passes scan.
                live_reg[scan_idx] <= 1'b0;
                if (live_reg[scan_idx])
                begin
                    live_reg[wr_reg[IDX_W-1:0]] <= 1'b1;
                    wr_reg <= wr_reg + 1'b1;
                end
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.pack_end)
            begin
                used_reg     <= wr_reg;
                head_reg     <= '0;
                tail_reg     <= '0;
                free_cnt_reg <= '0;
            end
        end
    end

    // The slot read data is registered and so arrives the cycle after the scan
    // pointer; the controller holds the pointer in a read state before each test.
    assign sts.scan_done = (scan_reg >= used_reg);
    assign sts.hit       = live_reg[scan_idx] && (slot_q_reg == value_reg);
    assign sts.rnd_done  = rnd_busy_reg && (bit_reg == 6'd0);
    assign sts.slot_live = live_reg[pos];
    assign sts.empty     = (used_reg == '0);
    assign sts.have_free = (free_cnt_reg != '0);
    assign sts.full      = (used_reg == LEN_W'(CAPACITY));
    assign sts.need_pack = ({free_cnt_reg, 1'b0} > {1'b0, used_reg});
    assign sts.pack_done = (scan_reg >= used_reg);
    assign slot_rdata    = slot_q_reg;
endmodule
`default_nettype wire

// ===== design/rst_ctrl.sv =====
// Controller state machine sequencing scans, division, and compaction.
`timescale 1ns / 1ps
`default_nettype none
module rst_ctrl import rst_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic  [1:0] in_action,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic       [2:0] status,
    output logic      [31:0] picked_value,
    input  wire logic [31:0] slot_rdata,
    input  wire rst_sts_t    sts,
    output rst_cmd_t         cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_TEST  = 4'd2;
    localparam logic [3:0] S_INS   = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_PRD   = 4'd5;
    localparam logic [3:0] S_PACK  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_GRD   = 4'd8;
    localparam logic [3:0] S_GOUT  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_FRD   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [1:0] act_reg, act_next;
    logic [2:0] status_reg, status_next;
    logic [31:0] pick_reg, pick_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            act_reg    <= ACT_INSERT;
            status_reg <= ST_DONE;
            pick_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            act_reg    <= act_next;
            status_reg <= status_next;
            pick_reg   <= pick_next;
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = (state_reg == S_OUT);
    assign status       = status_reg;
    assign picked_value = pick_reg;

    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        status_next = status_reg;
        pick_next   = pick_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    act_next    = in_action;
                    pick_next   = '0;
                    status_next = ST_REJECT;
                    if (in_action == ACT_INSERT || in_action == ACT_REMOVE)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next = S_RD;
                    end
                    else if (in_action == ACT_RANDOM)
                    begin
                        cmd.rnd_start = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_RD:
            begin
                state_next = sts.scan_done ? S_INS : S_TEST;
                if (sts.scan_done && act_reg == ACT_REMOVE)
                begin
                    status_next = ST_REJECT;
                    state_next  = S_OUT;
                end
            end
            S_TEST:
            begin
                if (sts.hit)
                begin
                    if (act_reg == ACT_INSERT)
                    begin
                        status_next = ST_REJECT;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        cmd.do_remove = 1'b1;
                        status_next   = ST_DONE;
                        state_next    = S_CHK;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next = S_RD;
                end
            end
            S_INS:
            begin
                if (sts.have_free)
                begin
                    state_next = S_FRD;
                end
                else if (sts.full)
                begin
                    status_next = ST_FULL;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.do_insert = 1'b1;
                    status_next   = ST_DONE;
                    state_next    = S_OUT;
                end
            end
            S_FRD:
            begin
                cmd.do_insert = 1'b1;
                cmd.fifo_rd   = 1'b1;
                status_next   = ST_DONE;
                state_next    = S_OUT;
            end
            S_CHK:
            begin
                if (sts.need_pack)
                begin
                    cmd.scan_start = 1'b1;
                    state_next = S_PRD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_PRD:
            begin
                if (sts.pack_done)
                begin
                    cmd.pack_end = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_PACK;
                end
            end
            S_PACK:
            begin
                cmd.pack_step = 1'b1;
                state_next = S_PRD;
            end
            S_DIV:
            begin
                cmd.rnd_step = 1'b1;
                if (sts.empty)
                begin
                    status_next = ST_EMPTY;
                    state_next  = S_OUT;
                end
                else if (sts.rnd_done)
                begin
                    state_next = S_GRD;
                end
            end
            S_GRD:
            begin
                cmd.rd_slot = 1'b1;
                state_next = S_GOUT;
            end
            S_GOUT:
            begin
                if (sts.slot_live)
                begin
                    status_next = ST_DONE;
                    pick_next   = slot_rdata;
                end
                else
                begin
                    status_next = ST_RETRY;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the randomized set table unit.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: keeps a shadow copy of the set and a queue of predicted results.
class set_table_scoreboard;
    logic [31:0] slot_val [rst_pkg::CAPACITY];
    bit          slot_on [rst_pkg::CAPACITY];
    int          used_len;
    int          fifo_idx [rst_pkg::CAPACITY];
    int          fhead;
    int          ftail;
    int          fcount;
    logic [2:0]  want_status [$];
    logic [31:0] want_pick [$];
    int          errors;

    function new();
        used_len = 0;
        fhead = 0;
        ftail = 0;
        fcount = 0;
        errors = 0;
        foreach (slot_on[i]) slot_on[i] = 0;
    endfunction

    function int find_slot(logic [31:0] v);
        for (int i = 0; i < used_len; i++)
            if (slot_on[i] && slot_val[i] == v)
                return i;
        return -1;
    endfunction

    function void pack_slots();
        int n;
        n = 0;
        for (int i = 0; i < used_len; i++)
            if (slot_on[i])
            begin
                slot_val[n] = slot_val[i];
                slot_on[n] = 1;
                n++;
            end
        for (int i = n; i < rst_pkg::CAPACITY; i++)
            slot_on[i] = 0;
        used_len = n;
        fhead = 0;
        ftail = 0;
        fcount = 0;
    endfunction

    // Applies one accepted request to the shadow set and queues its result.
    function void note_request(logic [1:0] act, logic [31:0] v, logic [31:0] rnd);
        logic [2:0] st;
        logic [31:0] pick;
        int pos;
        st = rst_pkg::ST_REJECT;
        pick = '0;
        if (act == rst_pkg::ACT_INSERT)
        begin
            if (find_slot(v) < 0)
            begin
                st = rst_pkg::ST_DONE;
                if (fcount > 0)
                begin
                    pos = fifo_idx[fhead];
                    fhead = (fhead + 1) % rst_pkg::CAPACITY;
                    fcount--;
                end
                else if (used_len >= rst_pkg::CAPACITY)
                begin
                    st = rst_pkg::ST_FULL;
                    pos = -1;
                end
                else
                begin
                    pos = used_len;
                    used_len++;
                end
                if (pos >= 0)
                begin
                    slot_val[pos] = v;
                    slot_on[pos] = 1;
                end
            end
        end
        else if (act == rst_pkg::ACT_REMOVE)
        begin
            pos = find_slot(v);
            if (pos >= 0)
            begin
                st = rst_pkg::ST_DONE;
                slot_on[pos] = 0;
                fifo_idx[ftail] = pos;
                ftail = (ftail + 1) % rst_pkg::CAPACITY;
                fcount++;
                if (2 * fcount > used_len)
                    pack_slots();
            end
        end
        else if (act == rst_pkg::ACT_RANDOM)
        begin
            if (used_len == 0)
                st = rst_pkg::ST_EMPTY;
            else
            begin
                pos = rnd % used_len;
                if (slot_on[pos])
                begin
                    st = rst_pkg::ST_DONE;
                    pick = slot_val[pos];
                end
                else
                    st = rst_pkg::ST_RETRY;
            end
        end
        want_status.insert(want_status.size(), st);
        want_pick.insert(want_pick.size(), pick);
    endfunction

    // Compares one result transfer with the oldest prediction.
    function void check_result(logic [2:0] st, logic [31:0] pick);
        logic [2:0] es;
        logic [31:0] ep;
        if (want_status.size() == 0)
        begin
            $display("%0t: unexpected result status=%0d picked=%h", $time, st, pick);
            errors++;
            return;
        end
        es = want_status.pop_front();
        ep = want_pick.pop_front();
        if (st !== es)
        begin
            $display("%0t: status expected %0d actual %0d", $time, es, st);
            errors++;
        end
        if (pick !== ep)
        begin
            $display("%0t: picked_value expected %h actual %h", $time, ep, pick);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import rst_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    // Action code that the block does not define; it must be rejected.
    localparam logic [1:0] ACT_UNKNOWN = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] action = ACT_INSERT;
    logic signed [31:0] item_value = '0;
    logic [31:0] random_word = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] status;
    logic signed [31:0] picked_value;

    set_table_scoreboard sb;
    logic [31:0] value_pool [16];
    bit hold_receiver = 1'b0;
    int idle_cycles = 0;

    randomized_set_table_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .item_value(item_value), .random_word(random_word),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .picked_value(picked_value)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 120);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // Offers one request and holds it until the transfer happens.
    task automatic send_request(logic [1:0] act, logic [31:0] v, logic [31:0] rnd);
        action <= act;
        item_value <= v;
        random_word <= rnd;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(act, v, rnd);
    endtask

    task automatic send_gap(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (sb.want_status.size() != 0)
            @(posedge clk);
    endtask

    // Picks a request biased toward a small pool of values so that hits,
    // reuse of freed slots and compaction happen often.
    task automatic send_random_request();
        logic [1:0] act;
        logic [31:0] v;
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            act = ACT_INSERT;
        else if (r < 75)
            act = ACT_REMOVE;
        else if (r < 98)
            act = ACT_RANDOM;
        else
            act = ACT_UNKNOWN;
        if ($urandom_range(0, 3) == 0)
            v = $urandom;
        else
            v = value_pool[$urandom_range(0, 15)] + $urandom_range(0, 40);
        send_request(act, v, $urandom);
    endtask

    // Receiver: random stalls, plus one long hold-off driven by the flag.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (hold_receiver)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_receiver = 1'b0;
            end
            n = gap_length();
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Results are sampled at the edge; the handshake was settled before it.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(status, picked_value);
    end

    // Watchdog: counts cycles in which neither channel transfers.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("randomized_set_table_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        foreach (value_pool[i])
            value_pool[i] = $urandom;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFD0;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFD0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty set, extremes of the value, duplicates,
        // absent removes, retry on a freed slot and the unknown action.
        send_request(ACT_RANDOM, 32'h0, 32'hFFFF_FFFF);
        send_request(ACT_REMOVE, 32'h5, 32'h0);
        send_request(ACT_INSERT, 32'h8000_0000, 32'h0);
        send_request(ACT_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_INSERT, 32'h0, 32'h0);
        send_request(ACT_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_request(ACT_INSERT, 32'h8000_0000, 32'h0);
        send_request(ACT_RANDOM, 32'hFFFF_FFFF, 32'h0);
        send_request(ACT_RANDOM, 32'h0, 32'hFFFF_FFFF);
        send_request(ACT_REMOVE, 32'h7FFF_FFFF, 32'h0);
        send_request(ACT_RANDOM, 32'h0, 32'h1);
        send_request(ACT_INSERT, 32'h1234_5678, 32'h0);
        send_request(ACT_UNKNOWN, 32'h1234_5678, 32'hFFFF_FFFF);
        send_request(ACT_REMOVE, 32'h8000_0000, 32'h0);
        send_request(ACT_REMOVE, 32'h0, 32'h0);
        send_request(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_request(ACT_REMOVE, 32'h1234_5678, 32'h0);
        send_request(ACT_RANDOM, 32'h0, 32'h7);

        // Fill the table to capacity and try one more insert.
        for (int i = 0; i <= CAPACITY; i++)
            send_request(ACT_INSERT, 32'h100 + i, 32'h0);

        // The sender pauses here until every prediction has been met.
        send_gap(1);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering requests.
        hold_receiver = 1'b1;
        for (int i = 0; i < 10; i++)
            send_request(ACT_RANDOM, 32'h0, $urandom);

        // Random part: removes aimed at the full table, then mixed traffic.
        for (int i = 0; i < 1350; i++)
        begin
            send_gap(gap_length());
            if (i < 70)
                send_request(ACT_REMOVE, 32'h100 + $urandom_range(0, 70), $urandom);
            else
                send_random_request();
        end
        in_valid <= 1'b0;
        wait_drained();
        repeat (300) @(posedge clk);

        if (sb.errors == 0 && sb.want_status.size() == 0)
            $display("randomized_set_table_unit: match");
        else
            $display("randomized_set_table_unit: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
